// ----- rtl/radix2_fft_in_place_macros.svh -----
// assertion macros for the in-place fft block
`ifndef RADIX2_FFT_IN_PLACE_MACROS_SVH
`define RADIX2_FFT_IN_PLACE_MACROS_SVH
`ifndef SYNTH
`define RFFT_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define RFFT_ASSERT_NEXT(lbl, clk, rstn, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) pre |=> post) else $error(msg);
`else
`define RFFT_ASSERT(lbl, clk, rstn, prop, msg)
`define RFFT_ASSERT_NEXT(lbl, clk, rstn, pre, post, msg)
`endif
`endif

// ----- rtl/rfft_pkg.sv -----
// shared constants, codes and twiddle generation for the in-place fft
`timescale 1ns / 1ps
`default_nettype none
package rfft_pkg;

	localparam int WORD_W = 32;
	localparam int PT_W   = 2 * WORD_W;
	localparam int TW_W   = 32;

	localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;

	typedef enum logic [1:0] {
		REQ_LOAD = 2'd0,
		REQ_RUN  = 2'd1,
		REQ_READ = 2'd2,
		REQ_NONE = 2'd3
	} req_t;

	localparam logic [1:0] STAT_STORED   = 2'd0;
	localparam logic [1:0] STAT_FINISHED = 2'd1;
	localparam logic [1:0] STAT_BIN      = 2'd2;

	// clamp a q30 value into [0, 1.0], round half up to q15, saturate at 32767
	function automatic logic signed [15:0] q30_to_q15(input longint v);
		longint c;
		longint r;
		c = v;
		if (c < 0) c = 0;
		if (c > (64'sd1 <<< 30)) c = 64'sd1 <<< 30;
		r = (c + 16384) >>> 15;
		if (r > 32767) r = 32767;
		return 16'(r);
	endfunction

	// twiddle entry k of a table for 2^logn points: im in [31:16], re in [15:0]
	function automatic logic [31:0] tw_entry(input int k, input int logn);
		logic [63:0] quarter;
		logic [63:0] base;
		logic [63:0] kk;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] tc;
		logic [63:0] ts;
		logic [63:0] pc;
		logic [63:0] ps;
		longint sc;
		longint ss;
		logic signed [15:0] cq;
		logic signed [15:0] sq;
		logic signed [15:0] re;
		logic signed [15:0] im;
		logic second;
		quarter = (64'd1 << logn) >> 2;
		base = PI_Q60 >> (logn - 1);
		kk = 64'(k);
		second = 1'b0;
		if (quarter != 0 && kk >= quarter) begin
			kk = kk - quarter;
			second = 1'b1;
		end
		x = (base * kk + (64'd1 << 29)) >> 30;
		x2 = (x * x) >> 30;
		tc = 64'd1 << 30;
		ts = x;
		sc = longint'(tc);
		ss = longint'(ts);
		for (int n = 1; n <= 12; n++) begin
			pc = (tc * x2) >> 30;
			ps = (ts * x2) >> 30;
			case (n)
				1: begin tc = pc / 64'd2; ts = ps / 64'd6; end
				2: begin tc = pc / 64'd12; ts = ps / 64'd20; end
				3: begin tc = pc / 64'd30; ts = ps / 64'd42; end
				4: begin tc = pc / 64'd56; ts = ps / 64'd72; end
				5: begin tc = pc / 64'd90; ts = ps / 64'd110; end
				6: begin tc = pc / 64'd132; ts = ps / 64'd156; end
				7: begin tc = pc / 64'd182; ts = ps / 64'd210; end
				8: begin tc = pc / 64'd240; ts = ps / 64'd272; end
				9: begin tc = pc / 64'd306; ts = ps / 64'd342; end
				10: begin tc = pc / 64'd380; ts = ps / 64'd420; end
				11: begin tc = pc / 64'd462; ts = ps / 64'd506; end
				default: begin tc = pc / 64'd552; ts = ps / 64'd600; end
			endcase
			if (n % 2 == 1) begin
				sc = sc - longint'(tc);
				ss = ss - longint'(ts);
			end else begin
				sc = sc + longint'(tc);
				ss = ss + longint'(ts);
			end
		end
		cq = q30_to_q15(sc);
		sq = q30_to_q15(ss);
		if (second) begin
			re = -sq;
			im = -cq;
		end else begin
			re = cq;
			im = -sq;
		end
		return {im, re};
	endfunction

endpackage
`default_nettype wire

// ----- rtl/rfft_bfly.sv -----
// radix-2 butterfly datapath: registered products, then rounding and add/subtract
`timescale 1ns / 1ps
`default_nettype none
module rfft_bfly
	import rfft_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              load,
	input  wire logic [PT_W-1:0]   pt_a,
	input  wire logic [PT_W-1:0]   pt_b,
	input  wire logic [TW_W-1:0]   tw,
	output logic      [PT_W-1:0]   new_a,
	output logic      [PT_W-1:0]   new_b
);

	logic signed [47:0]       rr_s1;
	logic signed [47:0]       ii_s1;
	logic signed [47:0]       ri_s1;
	logic signed [47:0]       ir_s1;
	logic signed [WORD_W-1:0] ar_s1;
	logic signed [WORD_W-1:0] ai_s1;

	logic signed [49:0] sum_r;
	logic signed [49:0] sum_i;
	logic [WORD_W-1:0]  tr;
	logic [WORD_W-1:0]  ti;

	always_ff @(posedge clk) begin
		if (load) begin
			rr_s1 <= $signed(tw[15:0]) * $signed(pt_b[WORD_W-1:0]);
			ii_s1 <= $signed(tw[31:16]) * $signed(pt_b[PT_W-1:WORD_W]);
			ri_s1 <= $signed(tw[15:0]) * $signed(pt_b[PT_W-1:WORD_W]);
			ir_s1 <= $signed(tw[31:16]) * $signed(pt_b[WORD_W-1:0]);
			ar_s1 <= $signed(pt_a[WORD_W-1:0]);
			ai_s1 <= $signed(pt_a[PT_W-1:WORD_W]);
		end
	end

	// round at bit 14, keep the low word of the arithmetic shift
	always_comb begin
		sum_r = 50'(rr_s1) - 50'(ii_s1) + 50'sd16384;
		sum_i = 50'(ri_s1) + 50'(ir_s1) + 50'sd16384;
		tr = sum_r[46:15];
		ti = sum_i[46:15];
		new_a = {WORD_W'(ai_s1 + ti), WORD_W'(ar_s1 + tr)};
		new_b = {WORD_W'(ai_s1 - ti), WORD_W'(ar_s1 - tr)};
	end

endmodule
`default_nettype wire

// ----- rtl/radix2_fft_in_place.sv -----
// top level of the in-place radix-2 fft with point memory and sequencer
`timescale 1ns / 1ps
`default_nettype none
// In-place radix-2 decimation-in-time FFT over POINTS complex points held in one
// single-write, dual-read synchronous memory of 64-bit words (real low, imaginary
// high). After reset the block clears every memory word and holds in_stall high
// meanwhile. A load writes the sample at its bit-reversed address; a read goes
// through the registered read port first. A run passes over every butterfly of
// every stage: each butterfly goes through the memory read, the product register,
// and two write-backs over the single write port. Results leave through an output
// register, one per load, read or run request.
module radix2_fft_in_place
	import rfft_pkg::*;
#(
	parameter int POINTS = 1024
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [1:0]         req_type,
	input  wire logic [9:0]         point_index,
	input  wire logic signed [15:0] sample_value,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [1:0]              status,
	output logic signed [31:0]      bin_real,
	output logic signed [31:0]      bin_imag
);

`include "radix2_fft_in_place_macros.svh"

	localparam int AW    = (POINTS > 2) ? $clog2(POINTS) : 1;
	localparam int HALF  = POINTS / 2;
	localparam int TAW   = (AW > 1) ? AW - 1 : 1;
	localparam int SW    = (AW > 1) ? $clog2(AW) : 1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RDBIN,
		ST_BRD,
		ST_BMUL,
		ST_BWB,
		ST_BWA,
		ST_DONE
	} state_t;

	state_t state_q;

	logic [PT_W-1:0] mem [POINTS];
	logic [PT_W-1:0] rd_a_q;
	logic [PT_W-1:0] rd_b_q;
	logic [TW_W-1:0] tw_q;
	logic [TW_W-1:0] rom_w [HALF];

	logic [AW-1:0]  clr_q;
	logic [SW-1:0]  stage_q;
	logic [TAW-1:0] bfly_q;

	logic            out_valid_q;
	logic [1:0]      status_q;
	logic [PT_W-1:0] bin_q;

	logic            accept;
	logic            out_free;
	logic            out_set;
	logic [AW-1:0]   idx;
	logic [AW-1:0]   idx_rev;
	logic [AW-1:0]   bext;
	logic [AW-1:0]   mask;
	logic [AW-1:0]   step;
	logic [AW-1:0]   addr_a;
	logic [AW-1:0]   addr_b;
	logic [TAW-1:0]  tw_addr;
	logic [AW-1:0]   rd_addr_a;
	logic            we;
	logic [AW-1:0]   wr_addr;
	logic [PT_W-1:0] wr_data;
	logic [PT_W-1:0] new_a;
	logic [PT_W-1:0] new_b;
	logic            last_bfly;
	logic            last_stage;

	// twiddle table built at elaboration
	for (genvar k = 0; k < HALF; k++) begin : g_rom
		localparam logic [TW_W-1:0] TW = tw_entry(k, AW);
		assign rom_w[k] = TW;
	end

	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != ST_IDLE) || !out_free;
	assign accept   = in_valid && !in_stall;
	assign idx      = AW'(point_index);

	// a new result enters the output register this cycle
	assign out_set  = (accept && (req_type == REQ_LOAD)) || (state_q == ST_RDBIN) ||
		((state_q == ST_DONE) && out_free);

	always_comb begin
		for (int b = 0; b < AW; b++) begin
			idx_rev[b] = idx[AW-1-b];
		end
	end

	// butterfly addresses: insert a zero at bit position stage into the counter
	always_comb begin
		bext    = AW'(bfly_q);
		mask    = (AW'(1) << stage_q) - AW'(1);
		step    = AW'(1) << stage_q;
		addr_a  = ((bext >> stage_q) << (stage_q + 1)) | (bext & mask);
		addr_b  = addr_a | step;
		tw_addr = TAW'((bext & mask) << (AW - 1 - int'(stage_q)));
	end

	assign last_bfly  = (bfly_q == TAW'(HALF - 1));
	assign last_stage = (stage_q == SW'(AW - 1));
	assign rd_addr_a  = (state_q == ST_IDLE) ? idx : addr_a;

	always_comb begin
		we      = 1'b0;
		wr_addr = addr_a;
		wr_data = new_a;
		case (state_q)
			ST_CLEAR: begin
				we      = 1'b1;
				wr_addr = clr_q;
				wr_data = '0;
			end
			ST_IDLE: begin
				we      = accept && (req_type == REQ_LOAD);
				wr_addr = idx_rev;
				wr_data = {{WORD_W{1'b0}}, WORD_W'(sample_value)};
			end
			ST_BWB: begin
				we      = 1'b1;
				wr_addr = addr_b;
				wr_data = new_b;
			end
			ST_BWA: begin
				we      = 1'b1;
				wr_addr = addr_a;
				wr_data = new_a;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
		rd_a_q <= mem[rd_addr_a];
		rd_b_q <= mem[addr_b];
		tw_q   <= rom_w[tw_addr];
	end

	rfft_bfly u_bfly (
		.clk   (clk),
		.load  (state_q == ST_BMUL),
		.pt_a  (rd_a_q),
		.pt_b  (rd_b_q),
		.tw    (tw_q),
		.new_a (new_a),
		.new_b (new_b)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			stage_q     <= '0;
			bfly_q      <= '0;
			out_valid_q <= 1'b0;
			status_q    <= STAT_STORED;
			bin_q       <= '0;
		end else begin
			if (out_set) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(POINTS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						case (req_type)
							REQ_LOAD: begin
								status_q    <= STAT_STORED;
								bin_q       <= '0;
							end
							REQ_RUN: begin
								stage_q <= '0;
								bfly_q  <= '0;
								state_q <= ST_BRD;
							end
							REQ_READ: begin
								state_q <= ST_RDBIN;
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_RDBIN: begin
					status_q    <= STAT_BIN;
					bin_q       <= rd_a_q;
					state_q     <= ST_IDLE;
				end
				ST_BRD: begin
					state_q <= ST_BMUL;
				end
				ST_BMUL: begin
					state_q <= ST_BWB;
				end
				ST_BWB: begin
					state_q <= ST_BWA;
				end
				ST_BWA: begin
					if (last_bfly) begin
						bfly_q <= '0;
						if (last_stage) begin
							state_q <= ST_DONE;
						end else begin
							stage_q <= stage_q + SW'(1);
							state_q <= ST_BRD;
						end
					end else begin
						bfly_q  <= bfly_q + TAW'(1);
						state_q <= ST_BRD;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						status_q    <= STAT_FINISHED;
						bin_q       <= '0;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign bin_real  = $signed(bin_q[WORD_W-1:0]);
	assign bin_imag  = $signed(bin_q[PT_W-1:WORD_W]);

	`RFFT_ASSERT(a_clear_blocks, clk, arst_n, (state_q == ST_CLEAR) |-> in_stall, "input taken during clear")
	`RFFT_ASSERT_NEXT(a_load_result, clk, arst_n, accept && (req_type == REQ_LOAD), out_valid && (status == STAT_STORED), "load gave no result")
	`RFFT_ASSERT(a_pair_addr, clk, arst_n, (state_q == ST_BWB) |-> (addr_b == (addr_a | step)) && ((addr_a & step) == '0), "butterfly pair mismatch")
	`RFFT_ASSERT_NEXT(a_read_result, clk, arst_n, state_q == ST_RDBIN, out_valid && (status == STAT_BIN), "read gave no result")

endmodule
`default_nettype wire

// ----- tb/radix2_fft_in_place_checker.sv -----
// checker for the in-place fft: predicts every result and compares it field by field
`timescale 1ns / 1ps
module radix2_fft_in_place_checker
	import rfft_pkg::*;
#(
	parameter int POINTS = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic [1:0]         req_type,
	input  logic [9:0]         point_index,
	input  logic signed [15:0] sample_value,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic [1:0]         status,
	input  logic signed [31:0] bin_real,
	input  logic signed [31:0] bin_imag,
	output int                 errors,
	output int                 waiting
);

	typedef struct {
		logic [1:0]  st;
		logic [31:0] re;
		logic [31:0] im;
	} bin_result_t;

	localparam int LOGN = $clog2(POINTS);

	logic [63:0] spectrum [POINTS];
	longint tw_re [POINTS/2];
	longint tw_im [POINTS/2];
	bin_result_t pending_bins [$];

	function automatic longint to_q15(input longint v);
		longint c;
		longint r;
		c = v;
		if (c < 0) c = 0;
		if (c > (64'sd1 <<< 30)) c = 64'sd1 <<< 30;
		r = (c + 16384) >>> 15;
		return (r > 32767) ? 32767 : r;
	endfunction

	// quarter-wave table from a q30 series, second quarter by symmetry
	function automatic void build_twiddles();
		longint unsigned base;
		longint unsigned kk;
		longint unsigned x;
		longint unsigned x2;
		longint unsigned tc;
		longint unsigned ts;
		longint sc;
		longint ss;
		longint cq;
		longint sq;
		bit second;
		base = PI_Q60 >> (LOGN - 1);
		for (int k = 0; k < POINTS / 2; k++) begin
			kk = k;
			second = 0;
			if (POINTS / 4 != 0 && k >= POINTS / 4) begin
				kk = k - POINTS / 4;
				second = 1;
			end
			x = (base * kk + (64'd1 << 29)) >> 30;
			x2 = (x * x) >> 30;
			tc = 64'd1 << 30;
			ts = x;
			sc = tc;
			ss = ts;
			for (int n = 1; n <= 12; n++) begin
				tc = ((tc * x2) >> 30) / longint'((2 * n - 1) * (2 * n));
				ts = ((ts * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
				if (n % 2 == 1) begin
					sc -= tc;
					ss -= ts;
				end else begin
					sc += tc;
					ss += ts;
				end
			end
			cq = to_q15(sc);
			sq = to_q15(ss);
			tw_re[k] = second ? -sq : cq;
			tw_im[k] = second ? -cq : -sq;
		end
	endfunction

	function automatic int bit_rev(input int v);
		int r;
		r = 0;
		for (int b = 0; b < LOGN; b++)
			r = (r << 1) | ((v >> b) & 1);
		return r;
	endfunction

	function automatic void transform();
		int step;
		int lvl;
		longint ur, ui, ar, ai, br, bi, tr, ti;
		logic [31:0] nr, ni;
		step = 1;
		lvl = 1;
		while (step < POINTS) begin
			for (int j = 0; j < step; j++) begin
				ur = tw_re[j * (POINTS >> lvl)];
				ui = tw_im[j * (POINTS >> lvl)];
				for (int i = j; i < POINTS; i += 2 * step) begin
					ar = longint'($signed(spectrum[i][31:0]));
					ai = longint'($signed(spectrum[i][63:32]));
					br = longint'($signed(spectrum[i + step][31:0]));
					bi = longint'($signed(spectrum[i + step][63:32]));
					tr = (ur * br - ui * bi + 16384) >>> 15;
					ti = (ur * bi + ui * br + 16384) >>> 15;
					nr = 32'(ar - tr);
					ni = 32'(ai - ti);
					spectrum[i + step] = {ni, nr};
					nr = 32'(ar + tr);
					ni = 32'(ai + ti);
					spectrum[i] = {ni, nr};
				end
			end
			step <<= 1;
			lvl++;
		end
	endfunction

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
		errors++;
	endtask

	initial begin
		errors = 0;
		for (int i = 0; i < POINTS; i++) spectrum[i] = '0;
		build_twiddles();
	end

	assign waiting = pending_bins.size();

	always @(posedge clk) begin
		bin_result_t e;
		int idx;
		if (arst_n && in_valid && !in_stall) begin
			idx = int'(point_index) & (POINTS - 1);
			e.re = '0;
			e.im = '0;
			case (req_t'(req_type))
				REQ_LOAD: begin
					spectrum[bit_rev(idx)] = {32'd0, 32'($signed(sample_value))};
					e.st = STAT_STORED;
					pending_bins.push_back(e);
				end
				REQ_RUN: begin
					transform();
					e.st = STAT_FINISHED;
					pending_bins.push_back(e);
				end
				REQ_READ: begin
					e.st = STAT_BIN;
					e.re = spectrum[idx][31:0];
					e.im = spectrum[idx][63:32];
					pending_bins.push_back(e);
				end
				default: ;
			endcase
		end
		if (arst_n && out_valid && !out_stall) begin
			if (pending_bins.size() == 0) begin
				report("unexpected transfer status", 32'(status), 32'd0);
			end else begin
				e = pending_bins.pop_front();
				if (status !== e.st) report("status", 32'(status), 32'(e.st));
				if (bin_real !== e.re) report("bin_real", bin_real, e.re);
				if (bin_imag !== e.im) report("bin_imag", bin_imag, e.im);
			end
		end
	end

endmodule

// ----- tb/radix2_fft_in_place_test.sv -----
// top of the in-place fft testbench: stimulus, receiver stalls and verdict
`timescale 1ns / 1ps
module radix2_fft_in_place_test;
	import rfft_pkg::*;

	localparam int POINTS = 1024;
	localparam int CYCLE_LIMIT = 1500000;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [1:0]         req_type;
	logic [9:0]         point_index;
	logic signed [15:0] sample_value;
	logic               out_valid;
	logic               out_stall;
	logic [1:0]         status;
	logic signed [31:0] bin_real;
	logic signed [31:0] bin_imag;
	int                 errors;
	int                 waiting;
	int                 cycles;
	int                 burst_left;

	radix2_fft_in_place #(.POINTS(POINTS)) DUT (.*);
	radix2_fft_in_place_checker #(.POINTS(POINTS)) chk (.*);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	initial cycles = 0;
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// receiver: one long hold early on so the block backs up, then mixed stall patterns
	initial begin
		int mode;
		out_stall = 1'b0;
		wait (arst_n === 1'b1);
		repeat (1100) @(posedge clk);
		out_stall <= 1'b1;
		repeat (3000) @(posedge clk);
		forever begin
			mode = $urandom_range(0, 2);
			repeat ($urandom_range(20, 300)) begin
				case (mode)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 3) == 0);
					default: out_stall <= ($urandom_range(0, 9) < 7);
				endcase
				@(posedge clk);
			end
		end
	end

	// hold the item until the transfer, then maybe close the burst with a gap
	task automatic offer(input req_t r, input int idx, input int val);
		req_type <= r;
		point_index <= 10'(idx);
		sample_value <= 16'(val);
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = $urandom_range(0, 20);
		end else begin
			burst_left--;
		end
	endtask

	initial begin
		int pick;
		in_valid = 1'b0;
		req_type = REQ_LOAD;
		point_index = '0;
		sample_value = '0;
		burst_left = 5;
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		offer(REQ_READ, 5, 0);
		offer(REQ_LOAD, 0, 32767);
		offer(REQ_LOAD, 1023, -32768);
		offer(REQ_LOAD, 341, 16'h5555);
		offer(REQ_LOAD, 682, 16'hAAAA);
		offer(REQ_NONE, 1023, -1);
		offer(REQ_READ, 0, 0);
		offer(REQ_READ, 1023, 0);
		offer(REQ_RUN, 0, 0);
		offer(REQ_READ, 0, 0);
		offer(REQ_READ, 1, 0);
		offer(REQ_READ, 512, 0);
		offer(REQ_READ, 1023, 0);
		offer(REQ_READ, 341, 0);
		offer(REQ_RUN, 1023, 123);
		offer(REQ_READ, 256, 0);
		offer(REQ_READ, 768, 0);

		for (int n = 0; n < 450; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 2)
				offer(REQ_RUN, $urandom_range(0, 1023), $urandom_range(0, 65535));
			else if (pick < 5)
				offer(REQ_NONE, $urandom_range(0, 1023), $urandom_range(0, 65535));
			else if (pick < 30)
				offer(REQ_READ, $urandom_range(0, 1023), $urandom_range(0, 65535));
			else
				offer(REQ_LOAD, $urandom_range(0, 1023), $urandom_range(0, 65535));
		end
		offer(REQ_RUN, 0, 0);
		offer(REQ_READ, 0, 0);
		offer(REQ_READ, 1023, 0);
		in_valid <= 1'b0;

		while (waiting != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
